>>> rtl/core/rwav_pkg.sv
// Shared types and constants for the WAV stream decoder.
// Holds the result record, result kinds, status codes and RIFF tags.
// No dependencies.
package rwav_pkg;

   localparam int RESULT_FIFO_DEPTH = 4;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_FORMAT = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TOO_SMALL = 3'd1;
   localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
   localparam logic [2:0] ST_NO_FMT    = 3'd3;
   localparam logic [2:0] ST_NO_DATA   = 3'd4;
   localparam logic [2:0] ST_NO_CHAN   = 3'd5;
   localparam logic [2:0] ST_BAD_DEPTH = 3'd6;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [15:0] FMT_FLOAT = 16'h0003;
   localparam logic [15:0] FMT_EXT   = 16'hFFFE;
   localparam logic [5:0]  MIN_FILE  = 6'd44;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] sample_value;
      logic [15:0] sample_channel;
      logic        sample_is_float;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [15:0] bits_per_sample;
      logic        format_is_float;
      logic [2:0]  status;
      logic        last_of_run;
   } result_type;

endpackage

>>> rtl/core/riff_wave_pcm_stream_decoder_core.sv
// Top level of the WAV byte-stream decoder.
// Instantiates rwav_parser and rwav_result_fifo; depends on rwav_pkg.
//
// The decoder takes one file byte per request, one request per cycle, and
// answers with samples, one format result at the start of the data chunk and
// one end status on the byte marked end of file. A request is registered,
// decoded once the result queue has room, and its results are written to
// that queue, whose head drives the response channel. A byte can cause two
// results (last sample or format result, then the end status); the result
// queue holds FifoDepth entries, and requests are taken whenever it has two
// free entries, which with the default depth sustains one byte per cycle
// while responses are taken every cycle.
module riff_wave_pcm_stream_decoder_core #(
   parameter int FifoDepth = rwav_pkg::RESULT_FIFO_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_file,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_sample_value,
   output logic [15:0]        rsp_sample_channel,
   output logic               rsp_sample_is_float,
   output logic [15:0]        rsp_channel_count,
   output logic [31:0]        rsp_sample_rate,
   output logic [15:0]        rsp_bits_per_sample,
   output logic               rsp_format_is_float,
   output logic [2:0]         rsp_status,
   output logic               rsp_last_of_run
);
   import rwav_pkg::*;

   logic       room2;
   logic [1:0] push_cnt;
   result_type res0;
   result_type res1;
   result_type head;

   rwav_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_file (req_end_of_file),
      .room2           (room2),
      .push_cnt        (push_cnt),
      .res0            (res0),
      .res1            (res1)
   );

   rwav_result_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .res0      (res0),
      .res1      (res1),
      .room2     (room2),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_kind            = head.kind;
   assign rsp_sample_value    = head.sample_value;
   assign rsp_sample_channel  = head.sample_channel;
   assign rsp_sample_is_float = head.sample_is_float;
   assign rsp_channel_count   = head.channel_count;
   assign rsp_sample_rate     = head.sample_rate;
   assign rsp_bits_per_sample = head.bits_per_sample;
   assign rsp_format_is_float = head.format_is_float;
   assign rsp_status          = head.status;
   assign rsp_last_of_run     = head.last_of_run;

endmodule

>>> rtl/core/rwav_parser.sv
// Byte parser of the WAV stream decoder: input register, chunk walker,
// format capture and sample assembly, giving up to two results per byte.
// Depends on rwav_pkg.
module rwav_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_file,
   input  logic               room2,
   output logic [1:0]         push_cnt,
   output rwav_pkg::result_type res0,
   output rwav_pkg::result_type res1
);
   import rwav_pkg::*;

   typedef enum logic [2:0] {
      PH_RIFF, PH_HDR, PH_BODY, PH_DATA, PH_PAD, PH_HALT
   } phase_type;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_eof_ff;
   logic        advance;

   phase_type   phase_ff, phase_in;
   logic [5:0]  hbc_ff, hbc_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  off_ff, off_in;
   logic        pad_ff, pad_in;
   logic [15:0] fmt_tag_ff, fmt_tag_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] depth_ff, depth_in;
   logic [1:0]  float_ff, float_in;
   logic        have_fmt_ff, have_fmt_in;
   logic        have_smp_ff, have_smp_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  bis_ff, bis_in;
   logic [15:0] ci_ff, ci_in;
   logic [2:0]  err_ff, err_in;

   assign advance   = in_valid_ff && room2;
   assign req_ready = !in_valid_ff || room2;

   always_comb begin
      logic [7:0]  b;
      logic [32:0] size;
      logic        fmt_ok;
      logic [2:0]  st;
      logic [1:0]  last;
      logic [31:0] acc_new;
      logic        isf;
      logic [31:0] v;
      result_type  r_fmt;
      result_type  r_smp;
      result_type  r_end;
      logic        have_first;

      b        = in_byte_ff;
      size     = {1'b0, rem_ff} + {27'd0, off_ff};
      fmt_ok   = (tag_ff == TAG_FMT) && !have_smp_ff && (size >= 33'd16);
      st       = ST_OK;
      last     = (depth_ff[4:3] == 2'd0) ? 2'd3 : depth_ff[4:3] - 2'd1;
      acc_new  = acc_ff | ({24'd0, b} << {bis_ff, 3'b000});
      isf      = (float_ff == 2'd1) && (depth_ff == 16'd32);
      v        = '0;
      have_first = 1'b0;

      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end

      phase_in    = phase_ff;
      hbc_in      = (hbc_ff < MIN_FILE) ? hbc_ff + 6'd1 : hbc_ff;
      tag_in      = tag_ff;
      rem_in      = rem_ff;
      off_in      = off_ff;
      pad_in      = pad_ff;
      fmt_tag_in  = fmt_tag_ff;
      chan_in     = chan_ff;
      rate_in     = rate_ff;
      depth_in    = depth_ff;
      float_in    = float_ff;
      have_fmt_in = have_fmt_ff;
      have_smp_in = have_smp_ff;
      acc_in      = acc_ff;
      bis_in      = bis_ff;
      ci_in       = ci_ff;
      err_in      = err_ff;

      r_fmt = '0;
      r_fmt.kind            = KIND_FORMAT;
      r_fmt.channel_count   = chan_ff;
      r_fmt.sample_rate     = rate_ff;
      r_fmt.bits_per_sample = depth_ff;
      r_fmt.format_is_float = float_ff[0];
      r_smp = r_fmt;
      r_smp.kind            = KIND_SAMPLE;
      r_smp.sample_channel  = ci_ff;
      r_smp.sample_is_float = isf;

      unique case (phase_ff)
         PH_RIFF: begin
            tag_in = {tag_ff[23:0], b};
            if (off_ff == 6'd3 && tag_in != TAG_RIFF) begin
               err_in = ST_NOT_WAVE;
            end
            if (off_ff == 6'd11) begin
               if (tag_in != TAG_WAVE) begin
                  err_in = ST_NOT_WAVE;
               end
               off_in   = '0;
               phase_in = (err_in != ST_OK) ? PH_HALT : PH_HDR;
            end else begin
               off_in = off_ff + 6'd1;
            end
         end
         PH_HDR: begin
            if (off_ff < 6'd4) begin
               tag_in = {tag_ff[23:0], b};
               if (off_ff == 6'd0) begin
                  rem_in = '0;
               end
               off_in = off_ff + 6'd1;
            end else begin
               rem_in[{off_ff[1:0], 3'b000} +: 8] = b;
               if (off_ff < 6'd7) begin
                  off_in = off_ff + 6'd1;
               end else begin
                  pad_in = rem_in[0];
                  if (tag_ff == TAG_DATA && !have_smp_ff) begin
                     if (!have_fmt_ff) begin
                        st = ST_NO_FMT;
                     end else if (chan_ff == 16'd0) begin
                        st = ST_NO_CHAN;
                     end else if (depth_ff != 16'd8 && depth_ff != 16'd16 &&
                                  depth_ff != 16'd24 && depth_ff != 16'd32) begin
                        st = ST_BAD_DEPTH;
                     end
                     r_fmt.status = st;
                     have_first   = 1'b1;
                     if (st != ST_OK) begin
                        err_in   = st;
                        phase_in = PH_HALT;
                     end else begin
                        have_smp_in = 1'b1;
                        acc_in      = '0;
                        bis_in      = '0;
                        ci_in       = '0;
                        off_in      = '0;
                        phase_in    = (rem_in == 32'd0) ? PH_HDR : PH_DATA;
                     end
                  end else begin
                     off_in   = '0;
                     phase_in = (rem_in == 32'd0) ? PH_HDR : PH_BODY;
                  end
               end
            end
         end
         PH_BODY: begin
            if (fmt_ok) begin
               case (off_ff) inside
                  6'd0, 6'd1: fmt_tag_in[{off_ff[0], 3'b000} +: 8] = b;
                  6'd2, 6'd3: chan_in[{off_ff[0], 3'b000} +: 8] = b;
                  6'd4, 6'd5, 6'd6, 6'd7: rate_in[{off_ff[1:0], 3'b000} +: 8] = b;
                  6'd14: depth_in[7:0] = b;
                  6'd15: begin
                     depth_in[15:8] = b;
                     float_in       = {1'b0, fmt_tag_ff == FMT_FLOAT};
                     have_fmt_in    = 1'b1;
                  end
                  6'd24: begin
                     if (fmt_tag_ff == FMT_EXT && size >= 33'd40) begin
                        float_in = (b == FMT_FLOAT[7:0]) ? 2'd2 : 2'd0;
                     end
                  end
                  6'd25: begin
                     if (fmt_tag_ff == FMT_EXT && size >= 33'd40) begin
                        float_in = (float_ff == 2'd2 && b == FMT_FLOAT[15:8])
                                   ? 2'd1 : 2'd0;
                     end
                  end
                  default: ;
               endcase
            end
            rem_in = rem_ff - 32'd1;
            off_in = (off_ff < 6'd63) ? off_ff + 6'd1 : off_ff;
            if (rem_in == 32'd0) begin
               off_in   = '0;
               phase_in = pad_ff ? PH_PAD : PH_HDR;
            end
         end
         PH_DATA: begin
            if (bis_ff == last) begin
               if (isf || depth_ff == 16'd32) begin
                  v = acc_new;
               end else if (depth_ff == 16'd8) begin
                  v = {~acc_new[7], acc_new[6:0], 24'd0};
               end else if (depth_ff == 16'd16) begin
                  v = {acc_new[15:0], 16'd0};
               end else begin
                  v = {acc_new[23:0], 8'd0};
               end
               r_smp.sample_value = v;
               have_first = 1'b1;
               ci_in  = (({1'b0, ci_ff} + 17'd1) >= {1'b0, chan_ff}) ? 16'd0
                        : ci_ff + 16'd1;
               acc_in = '0;
               bis_in = '0;
            end else begin
               acc_in = acc_new;
               bis_in = bis_ff + 2'd1;
            end
            rem_in = rem_ff - 32'd1;
            if (rem_in == 32'd0) begin
               off_in   = '0;
               phase_in = pad_ff ? PH_PAD : PH_HDR;
            end
         end
         PH_PAD: begin
            phase_in = PH_HDR;
            off_in   = '0;
         end
         PH_HALT: ;
         default: ;
      endcase

      r_end = '0;
      r_end.kind            = KIND_END;
      r_end.channel_count   = chan_in;
      r_end.sample_rate     = rate_in;
      r_end.bits_per_sample = depth_in;
      r_end.format_is_float = float_in[0];
      r_end.last_of_run     = 1'b1;
      if (hbc_in < MIN_FILE) begin
         r_end.status = ST_TOO_SMALL;
      end else if (err_in != ST_OK) begin
         r_end.status = err_in;
      end else if (!have_fmt_in) begin
         r_end.status = ST_NO_FMT;
      end else if (!have_smp_in) begin
         r_end.status = ST_NO_DATA;
      end

      res0     = (phase_ff == PH_DATA) ? r_smp : r_fmt;
      res1     = r_end;
      push_cnt = 2'd0;
      if (advance) begin
         if (have_first) begin
            res0.last_of_run = !in_eof_ff;
            push_cnt = in_eof_ff ? 2'd2 : 2'd1;
         end else if (in_eof_ff) begin
            res0     = r_end;
            push_cnt = 2'd1;
         end
      end

      if (in_eof_ff) begin
         phase_in    = PH_RIFF;
         hbc_in      = '0;
         tag_in      = '0;
         rem_in      = '0;
         off_in      = '0;
         pad_in      = 1'b0;
         fmt_tag_in  = '0;
         chan_in     = '0;
         rate_in     = '0;
         depth_in    = '0;
         float_in    = '0;
         have_fmt_in = 1'b0;
         have_smp_in = 1'b0;
         acc_in      = '0;
         bis_in      = '0;
         ci_in       = '0;
         err_in      = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eof_ff  <= req_end_of_file;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_RIFF;
         hbc_ff      <= '0;
         tag_ff      <= '0;
         rem_ff      <= '0;
         off_ff      <= '0;
         pad_ff      <= 1'b0;
         fmt_tag_ff  <= '0;
         chan_ff     <= '0;
         rate_ff     <= '0;
         depth_ff    <= '0;
         float_ff    <= '0;
         have_fmt_ff <= 1'b0;
         have_smp_ff <= 1'b0;
         acc_ff      <= '0;
         bis_ff      <= '0;
         ci_ff       <= '0;
         err_ff      <= ST_OK;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff    <= phase_in;
            hbc_ff      <= hbc_in;
            tag_ff      <= tag_in;
            rem_ff      <= rem_in;
            off_ff      <= off_in;
            pad_ff      <= pad_in;
            fmt_tag_ff  <= fmt_tag_in;
            chan_ff     <= chan_in;
            rate_ff     <= rate_in;
            depth_ff    <= depth_in;
            float_ff    <= float_in;
            have_fmt_ff <= have_fmt_in;
            have_smp_ff <= have_smp_in;
            acc_ff      <= acc_in;
            bis_ff      <= bis_in;
            ci_ff       <= ci_in;
            err_ff      <= err_in;
         end
      end
   end

   // Results are only produced when the queue can take two of them.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_cnt != 2'd0 |-> room2)
      else $error("result pushed without queue room");

   // A second result in one step is always the closing end status.
   a_second_is_end: assert property (@(posedge clock) disable iff (reset)
      push_cnt == 2'd2 |-> (res1.kind == KIND_END && res1.last_of_run &&
                            !res0.last_of_run && res0.kind != KIND_END))
      else $error("bad second result");

   // Sample decoding only runs after a format result was accepted.
   a_data_has_format: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> (have_smp_ff && have_fmt_ff && chan_ff != 16'd0))
      else $error("data phase without a valid format");

endmodule

>>> rtl/core/rwav_result_fifo.sv
// Result queue of the WAV stream decoder: takes up to two results per cycle
// and hands out one per cycle while the response channel is ready.
// Depends on rwav_pkg.
module rwav_result_fifo #(
   parameter int Depth = rwav_pkg::RESULT_FIFO_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_cnt,
   input  rwav_pkg::result_type res0,
   input  rwav_pkg::result_type res1,
   output logic                 room2,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rwav_pkg::result_type head
);
   import rwav_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

   result_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr1;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign room2     = (count_ff <= CntW'(Depth - 2));
   assign head      = mem_ff[rd_ptr_ff];
   assign wr_ptr1   = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_cnt == 2'd1) begin
         wr_ptr_in = wr_ptr1;
      end else if (push_cnt == 2'd2) begin
         wr_ptr_in = (wr_ptr1 == LastPtr) ? '0 : wr_ptr1 + PtrW'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + CntW'(push_cnt) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= res0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr1] <= res1;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("result queue overflow");

endmodule

>>> tb/sv/rwav_decode_checker.sv
`timescale 1ns / 100ps
// Response checker for the WAV byte-stream decoder: follows each accepted file byte through
// its own copy of the RIFF chunk walk and compares every response with the oldest one due.
// Depends on rwav_pkg.
module rwav_decode_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_file,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_kind,
   input  logic signed [31:0] rsp_sample_value,
   input  logic [15:0]        rsp_sample_channel,
   input  logic               rsp_sample_is_float,
   input  logic [15:0]        rsp_channel_count,
   input  logic [31:0]        rsp_sample_rate,
   input  logic [15:0]        rsp_bits_per_sample,
   input  logic               rsp_format_is_float,
   input  logic [2:0]         rsp_status,
   input  logic               rsp_last_of_run,
   output int unsigned        error_count,
   output int unsigned        results_pending
);
   import rwav_pkg::*;

   typedef enum logic [2:0] {
      WALK_RIFF,
      WALK_HEADER,
      WALK_BODY,
      WALK_SAMPLES,
      WALK_PAD,
      WALK_HALT
   } walk_phase_type;

   // The low bit is the float flag; the third value marks a sub-format whose low byte matched.
   localparam logic [1:0] FLOAT_NO       = 2'd0;
   localparam logic [1:0] FLOAT_YES      = 2'd1;
   localparam logic [1:0] FLOAT_LOW_SEEN = 2'd2;

   walk_phase_type phase;
   logic [5:0]  bytes_seen;
   logic [31:0] tag_shift;
   logic [31:0] body_left;
   logic [5:0]  body_offset;
   logic        pad_due;
   logic [15:0] fmt_tag;
   logic [15:0] num_channels;
   logic [31:0] rate;
   logic [15:0] depth;
   logic [1:0]  float_state;
   logic        fmt_seen;
   logic        in_samples;
   logic [31:0] sample_bits;
   logic [1:0]  sample_byte;
   logic [15:0] next_channel;
   logic [2:0]  latched_status;
   result_type  decoded_results[$];
   int unsigned fails = 0;

   function automatic void clear_walk();
      phase          = WALK_RIFF;
      bytes_seen     = '0;
      tag_shift      = '0;
      body_left      = '0;
      body_offset    = '0;
      pad_due        = 1'b0;
      fmt_tag        = '0;
      num_channels   = '0;
      rate           = '0;
      depth          = '0;
      float_state    = FLOAT_NO;
      fmt_seen       = 1'b0;
      in_samples     = 1'b0;
      sample_bits    = '0;
      sample_byte    = '0;
      next_channel   = '0;
      latched_status = ST_OK;
   endfunction

   function automatic result_type make_result(logic [1:0] kind, logic [31:0] value,
                                              logic [15:0] chan, logic is_float,
                                              logic [2:0] st);
      result_type r;
      r.kind            = kind;
      r.sample_value    = value;
      r.sample_channel  = chan;
      r.sample_is_float = is_float;
      r.channel_count   = num_channels;
      r.sample_rate     = rate;
      r.bits_per_sample = depth;
      r.format_is_float = float_state[0];
      r.status          = st;
      r.last_of_run     = 1'b0;
      return r;
   endfunction

   function automatic void capture_fmt(logic [7:0] b, logic [32:0] fmt_size);
      case (body_offset)
         6'd0:  fmt_tag[7:0]       = b;
         6'd1:  fmt_tag[15:8]      = b;
         6'd2:  num_channels[7:0]  = b;
         6'd3:  num_channels[15:8] = b;
         6'd4:  rate[7:0]          = b;
         6'd5:  rate[15:8]         = b;
         6'd6:  rate[23:16]        = b;
         6'd7:  rate[31:24]        = b;
         6'd14: depth[7:0]         = b;
         6'd15: begin
            depth[15:8] = b;
            float_state = (fmt_tag == FMT_FLOAT) ? FLOAT_YES : FLOAT_NO;
            fmt_seen    = 1'b1;
         end
         6'd24: begin
            if (fmt_tag == FMT_EXT && fmt_size >= 40)
               float_state = (b == FMT_FLOAT[7:0]) ? FLOAT_LOW_SEEN : FLOAT_NO;
         end
         6'd25: begin
            if (fmt_tag == FMT_EXT && fmt_size >= 40)
               float_state = (float_state == FLOAT_LOW_SEEN && b == FMT_FLOAT[15:8])
                             ? FLOAT_YES : FLOAT_NO;
         end
         default: ;
      endcase
   endfunction

   task automatic decode_wav_byte(input logic [7:0] b, input logic eof);
      result_type  run[$];
      logic [2:0]  st;
      logic [32:0] fmt_size;
      logic [1:0]  last_byte;
      logic [31:0] word;
      logic        is_float_sample;
      if (bytes_seen < MIN_FILE)
         bytes_seen++;
      case (phase)
         WALK_RIFF: begin
            tag_shift = {tag_shift[23:0], b};
            if (body_offset == 6'd3 && tag_shift != TAG_RIFF)
               latched_status = ST_NOT_WAVE;
            if (body_offset == 6'd11) begin
               if (tag_shift != TAG_WAVE)
                  latched_status = ST_NOT_WAVE;
               body_offset = '0;
               phase = (latched_status != ST_OK) ? WALK_HALT : WALK_HEADER;
            end else begin
               body_offset++;
            end
         end
         WALK_HEADER: begin
            if (body_offset < 6'd4) begin
               tag_shift = {tag_shift[23:0], b};
               if (body_offset == 6'd0)
                  body_left = '0;
               body_offset++;
            end else begin
               body_left |= 32'(b) << (8 * (body_offset - 6'd4));
               if (body_offset < 6'd7) begin
                  body_offset++;
               end else begin
                  pad_due = body_left[0];
                  if (tag_shift == TAG_DATA && !in_samples) begin
                     if (!fmt_seen)
                        st = ST_NO_FMT;
                     else if (num_channels == 16'd0)
                        st = ST_NO_CHAN;
                     else if (depth != 16'd8 && depth != 16'd16 && depth != 16'd24 &&
                              depth != 16'd32)
                        st = ST_BAD_DEPTH;
                     else
                        st = ST_OK;
                     run.insert(run.size(), make_result(KIND_FORMAT, '0, '0, 1'b0, st));
                     if (st != ST_OK) begin
                        latched_status = st;
                        phase = WALK_HALT;
                     end else begin
                        in_samples   = 1'b1;
                        sample_bits  = '0;
                        sample_byte  = '0;
                        next_channel = '0;
                        phase = WALK_SAMPLES;
                     end
                  end else begin
                     phase = WALK_BODY;
                  end
                  if (phase != WALK_HALT) begin
                     body_offset = '0;
                     if (body_left == 32'd0)
                        phase = WALK_HEADER;
                  end
               end
            end
         end
         WALK_BODY: begin
            fmt_size = {1'b0, body_left} + 33'(body_offset);
            if (tag_shift == TAG_FMT && !in_samples && fmt_size >= 16)
               capture_fmt(b, fmt_size);
            body_left--;
            if (body_offset < 6'd63)
               body_offset++;
            if (body_left == 32'd0) begin
               body_offset = '0;
               phase = pad_due ? WALK_PAD : WALK_HEADER;
            end
         end
         WALK_SAMPLES: begin
            last_byte = (depth[4:3] == 2'd0) ? 2'd3 : depth[4:3] - 2'd1;
            sample_bits |= 32'(b) << (8 * sample_byte);
            if (sample_byte == last_byte) begin
               is_float_sample = (float_state == FLOAT_YES) && (depth == 16'd32);
               if (depth == 16'd32)
                  word = sample_bits;
               else if (depth == 16'd8)
                  word = {sample_bits[7:0] ^ 8'h80, 24'h0};
               else if (depth == 16'd16)
                  word = {sample_bits[15:0], 16'h0};
               else
                  word = {sample_bits[23:0], 8'h0};
               run.insert(run.size(), make_result(KIND_SAMPLE, word, next_channel,
                                                  is_float_sample, ST_OK));
               next_channel = ({1'b0, next_channel} + 17'd1 >= {1'b0, num_channels})
                              ? 16'd0 : next_channel + 16'd1;
               sample_bits = '0;
               sample_byte = '0;
            end else begin
               sample_byte++;
            end
            body_left--;
            if (body_left == 32'd0) begin
               body_offset = '0;
               phase = pad_due ? WALK_PAD : WALK_HEADER;
            end
         end
         WALK_PAD: begin
            phase = WALK_HEADER;
            body_offset = '0;
         end
         default: ;
      endcase
      if (eof) begin
         if (bytes_seen < MIN_FILE)
            st = ST_TOO_SMALL;
         else if (latched_status != ST_OK)
            st = latched_status;
         else if (!fmt_seen)
            st = ST_NO_FMT;
         else if (!in_samples)
            st = ST_NO_DATA;
         else
            st = ST_OK;
         run.insert(run.size(), make_result(KIND_END, '0, '0, 1'b0, st));
         clear_walk();
      end
      if (run.size() > 0)
         run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i])
         decoded_results.insert(decoded_results.size(), run[i]);
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fails++;
      end
   endfunction

   task automatic check_response();
      result_type want;
      if (decoded_results.size() == 0) begin
         $display("%0t: unexpected response, expected none, actual kind %0d status %0d",
                  $time, rsp_kind, rsp_status);
         fails++;
      end else begin
         want = decoded_results.pop_front();
         compare_field("kind", want.kind, rsp_kind);
         compare_field("sample_value", want.sample_value, rsp_sample_value);
         compare_field("sample_channel", want.sample_channel, rsp_sample_channel);
         compare_field("sample_is_float", want.sample_is_float, rsp_sample_is_float);
         compare_field("channel_count", want.channel_count, rsp_channel_count);
         compare_field("sample_rate", want.sample_rate, rsp_sample_rate);
         compare_field("bits_per_sample", want.bits_per_sample, rsp_bits_per_sample);
         compare_field("format_is_float", want.format_is_float, rsp_format_is_float);
         compare_field("status", want.status, rsp_status);
         compare_field("last_of_run", want.last_of_run, rsp_last_of_run);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_walk();
         decoded_results.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_response();
         if (req_valid && req_ready)
            decode_wav_byte(req_data_byte, req_end_of_file);
      end
      error_count     = fails;
      results_pending = decoded_results.size();
   end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the WAV decoder testbench: clock, reset, file byte stimulus and the verdict.
// Instantiates riff_wave_pcm_stream_decoder_core and rwav_decode_checker; uses rwav_pkg.
module tb_top;
   import rwav_pkg::*;

   localparam int          STALL_LIMIT    = 2000;
   localparam int          HOLDOFF_CYCLES = 60;
   localparam int          RANDOM_BYTES   = 180;
   localparam logic [15:0] FMT_PCM        = 16'h0001;
   localparam logic [31:0] TAG_LIST       = 32'h4C49_5354;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_data_byte = '0;
   logic               req_end_of_file = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_kind;
   logic signed [31:0] rsp_sample_value;
   logic [15:0]        rsp_sample_channel;
   logic               rsp_sample_is_float;
   logic [15:0]        rsp_channel_count;
   logic [31:0]        rsp_sample_rate;
   logic [15:0]        rsp_bits_per_sample;
   logic               rsp_format_is_float;
   logic [2:0]         rsp_status;
   logic               rsp_last_of_run;

   int unsigned error_count;
   int unsigned results_pending;
   int unsigned send_idle_pct = 31;
   int unsigned recv_idle_pct = 86;
   int unsigned stall_cycles = 0;
   int unsigned random_bytes_sent = 0;
   logic        holdoff_request = 1'b0;
   logic [7:0]  wav_bytes[$];

   riff_wave_pcm_stream_decoder_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_end_of_file     (req_end_of_file),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_sample_value    (rsp_sample_value),
      .rsp_sample_channel  (rsp_sample_channel),
      .rsp_sample_is_float (rsp_sample_is_float),
      .rsp_channel_count   (rsp_channel_count),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_bits_per_sample (rsp_bits_per_sample),
      .rsp_format_is_float (rsp_format_is_float),
      .rsp_status          (rsp_status),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   rwav_decode_checker decode_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_end_of_file     (req_end_of_file),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_sample_value    (rsp_sample_value),
      .rsp_sample_channel  (rsp_sample_channel),
      .rsp_sample_is_float (rsp_sample_is_float),
      .rsp_channel_count   (rsp_channel_count),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_bits_per_sample (rsp_bits_per_sample),
      .rsp_format_is_float (rsp_format_is_float),
      .rsp_status          (rsp_status),
      .rsp_last_of_run     (rsp_last_of_run),
      .error_count         (error_count),
      .results_pending     (results_pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // The long hold-off lets the result queue fill so that the request side stalls.
   initial begin
      forever begin
         @(negedge clock);
         if (holdoff_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
            holdoff_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic void add_byte(logic [7:0] b);
      wav_bytes.insert(wav_bytes.size(), b);
   endfunction

   function automatic void put_le(logic [31:0] v, int n);
      for (int i = 0; i < n; i++)
         add_byte(v[8*i +: 8]);
   endfunction

   function automatic void put_tag(logic [31:0] t);
      for (int i = 3; i >= 0; i--)
         add_byte(t[8*i +: 8]);
   endfunction

   function automatic logic [7:0] pattern_byte(int unsigned i);
      case (i % 5)
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void put_junk(logic [31:0] tag, int unsigned size);
      put_tag(tag);
      put_le(size, 4);
      repeat (size) add_byte(8'($urandom));
      if (size % 2 == 1)
         add_byte(8'h00);
   endfunction

   function automatic void put_fmt(int unsigned size, logic [15:0] ftag, logic [15:0] chans,
                                   logic [31:0] rate, logic [15:0] depth, logic [15:0] sub);
      logic [127:0] fields;
      fields = {depth, 16'($urandom), 32'($urandom), rate, chans, ftag};
      put_tag(TAG_FMT);
      put_le(size, 4);
      for (int unsigned o = 0; o < size; o++) begin
         if (o < 16)
            add_byte(fields[8*o +: 8]);
         else if (o == 24)
            add_byte(sub[7:0]);
         else if (o == 25)
            add_byte(sub[15:8]);
         else
            add_byte(8'($urandom));
      end
      if (size % 2 == 1)
         add_byte(8'h00);
   endfunction

   function automatic void put_data(logic [31:0] size, int unsigned len, logic patterned);
      put_tag(TAG_DATA);
      put_le(size, 4);
      for (int unsigned i = 0; i < len; i++)
         add_byte(patterned ? pattern_byte(i) : 8'($urandom));
      if (len == size && size[0])
         add_byte(8'h00);
   endfunction

   function automatic void put_riff_header();
      put_tag(TAG_RIFF);
      put_le($urandom, 4);
      put_tag(TAG_WAVE);
   endfunction

   function automatic void put_wav(logic [15:0] ftag, logic [15:0] chans, logic [31:0] rate,
                                   logic [15:0] depth, int unsigned fmt_size,
                                   logic [15:0] sub, logic [31:0] data_size,
                                   int unsigned data_len);
      put_riff_header();
      put_fmt(fmt_size, ftag, chans, rate, depth, sub);
      put_data(data_size, data_len, 1'b1);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_end_of_file <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_wav();
      foreach (wav_bytes[i])
         send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
      wav_bytes.delete();
   endtask

   task automatic run_directed();
      put_wav(FMT_PCM, 16'd1, 32'd8000, 16'd8, 16, FMT_PCM, 6, 6);
      send_wav();
      put_wav(FMT_PCM, 16'd2, 32'd44100, 16'd16, 16, FMT_PCM, 9, 9);
      send_wav();
      put_wav(FMT_PCM, 16'd3, 32'd48000, 16'd24, 18, FMT_PCM, 12, 12);
      send_wav();
      put_wav(FMT_PCM, 16'd1, 32'd0, 16'd32, 16, FMT_PCM, 8, 8);
      send_wav();
      put_wav(FMT_FLOAT, 16'd2, 32'd96000, 16'd32, 16, FMT_PCM, 8, 8);
      send_wav();
      put_wav(FMT_EXT, 16'd1, 32'd48000, 16'd32, 40, FMT_FLOAT, 8, 8);
      send_wav();
      put_wav(FMT_EXT, 16'd1, 32'd48000, 16'd32, 40, FMT_PCM, 4, 4);
      send_wav();
      put_wav(FMT_FLOAT, 16'd1, 32'd22050, 16'd16, 16, FMT_PCM, 4, 4);
      send_wav();
      put_wav(FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'd16, 16, FMT_PCM, 32'hFFFF_FFFF, 10);
      send_wav();
      put_wav(FMT_PCM, 16'd0, 32'd8000, 16'd16, 16, FMT_PCM, 4, 4);
      send_wav();
      put_wav(FMT_PCM, 16'd1, 32'd8000, 16'd12, 16, FMT_PCM, 4, 4);
      send_wav();
      put_wav(FMT_PCM, 16'd1, 32'd8000, 16'd16, 16, FMT_PCM, 4, 4);
      wav_bytes[3] ^= 8'h01;
      send_wav();
      put_wav(FMT_PCM, 16'd1, 32'd8000, 16'd16, 16, FMT_PCM, 4, 4);
      wav_bytes[11] ^= 8'h80;
      send_wav();
      put_wav(FMT_PCM, 16'd1, 32'd8000, 16'd16, 16, FMT_PCM, 4, 4);
      while (wav_bytes.size() > 30)
         void'(wav_bytes.pop_back());
      send_wav();
      repeat (5) add_byte(8'($urandom));
      send_wav();
      add_byte(8'hFF);
      send_wav();
      // A data chunk with no format chunk ahead of it, and one after a short format chunk.
      put_riff_header();
      put_data(32, 32, 1'b1);
      send_wav();
      put_riff_header();
      put_fmt(8, FMT_PCM, 16'd1, 32'd8000, 16'd16, FMT_PCM);
      put_data(16, 16, 1'b1);
      send_wav();
      // An odd-sized chunk before the format, then data and format chunks that come too late,
      // then an unfinished chunk header.
      put_riff_header();
      put_junk(TAG_LIST, 3);
      put_fmt(16, FMT_PCM, 16'd2, 32'd8000, 16'd8, FMT_PCM);
      put_data(4, 4, 1'b1);
      put_data(3, 3, 1'b1);
      put_fmt(16, FMT_FLOAT, 16'd5, 32'd16000, 16'd32, FMT_PCM);
      repeat (5) add_byte(8'($urandom));
      send_wav();
      put_riff_header();
      put_fmt(16, FMT_PCM, 16'd1, 32'd8000, 16'd16, FMT_PCM);
      put_data(0, 0, 1'b1);
      put_junk(TAG_LIST, 2);
      send_wav();
      put_riff_header();
      put_fmt(16, FMT_PCM, 16'd1, 32'd8000, 16'd16, FMT_PCM);
      put_junk(TAG_LIST, 8);
      send_wav();
      // The file stops just after the low byte of the sub-format.
      put_riff_header();
      put_fmt(40, FMT_EXT, 16'd2, 32'd44100, 16'd32, FMT_FLOAT);
      while (wav_bytes.size() > 45)
         void'(wav_bytes.pop_back());
      send_wav();
   endtask

   task automatic make_random_file();
      int unsigned fmt_size;
      int unsigned data_len;
      int unsigned flip_at;
      logic [31:0] data_size;
      logic [15:0] ftag;
      logic [15:0] chans;
      logic [15:0] depth;
      logic [15:0] sub;
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 60)) add_byte(8'($urandom));
      end else begin
         put_riff_header();
         if ($urandom_range(3) == 0)
            put_junk(TAG_LIST, $urandom_range(0, 7));
         if ($urandom_range(19) != 0) begin
            case ($urandom_range(3))
               0:       fmt_size = 16;
               1:       fmt_size = 18;
               2:       fmt_size = 40;
               default: fmt_size = $urandom_range(0, 44);
            endcase
            case ($urandom_range(3))
               0:       ftag = FMT_PCM;
               1:       ftag = FMT_FLOAT;
               2:       ftag = FMT_EXT;
               default: ftag = 16'($urandom);
            endcase
            if ($urandom_range(9) < 8)
               chans = 16'($urandom_range(1, 4));
            else
               chans = $urandom_range(1) ? 16'd0 : 16'($urandom);
            case ($urandom_range(4))
               0:       depth = 16'd8;
               1:       depth = 16'd16;
               2:       depth = 16'd24;
               3:       depth = 16'd32;
               default: depth = $urandom_range(1) ? 16'($urandom_range(0, 40)) : 16'($urandom);
            endcase
            if ($urandom_range(1))
               sub = FMT_FLOAT;
            else
               sub = $urandom_range(1) ? FMT_PCM : 16'($urandom);
            put_fmt(fmt_size, ftag, chans, $urandom, depth, sub);
         end
         if ($urandom_range(4) == 0)
            put_junk(TAG_LIST, $urandom_range(0, 5));
         data_size = ($urandom_range(15) == 0) ? $urandom : $urandom_range(0, 30);
         data_len = ($urandom_range(3) == 0 || data_size > 30) ? $urandom_range(0, 30)
                                                                : data_size;
         if (data_len > data_size)
            data_len = data_size;
         put_data(data_size, data_len, 1'b0);
         if (data_len == data_size) begin
            if ($urandom_range(2) == 0)
               put_data($urandom_range(0, 6), $urandom_range(0, 6), 1'b0);
            if ($urandom_range(3) == 0)
               put_fmt(16, FMT_FLOAT, 16'($urandom), $urandom, 16'd32, FMT_PCM);
            if ($urandom_range(3) == 0)
               repeat ($urandom_range(1, 7)) add_byte(8'($urandom));
         end
         if ($urandom_range(9) == 0) begin
            flip_at = $urandom_range(0, wav_bytes.size() - 1);
            wav_bytes[flip_at] ^= 8'(1 << $urandom_range(7));
         end
      end
   endtask

   task automatic run_random(input int unsigned byte_goal);
      while (random_bytes_sent < byte_goal) begin
         make_random_file();
         random_bytes_sent += wav_bytes.size();
         send_wav();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(RANDOM_BYTES / 3);
      send_idle_pct = 86;
      recv_idle_pct = 31;
      run_random(2 * RANDOM_BYTES / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      holdoff_request = 1'b1;
      run_random(RANDOM_BYTES);
      req_valid <= 1'b0;
      while (results_pending != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
rtl/core/rwav_pkg.sv
rtl/core/rwav_parser.sv
rtl/core/rwav_result_fifo.sv
rtl/core/riff_wave_pcm_stream_decoder_core.sv
tb/sv/rwav_decode_checker.sv
tb/sv/tb_top.sv
